// ===== hdl/s88_fb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s88_fb_pkg: shared types and constants of the feedback bus master
// Bus phase numbers, store geometry, report states and the result beat type.
// ----------------------------------------------------------------------------
package s88_fb_pkg;

  localparam int unsigned MAX_MODULES     = 32;
  localparam int unsigned BITS_PER_MODULE = 8;
  localparam int unsigned MOD_IDX_W       = $clog2(MAX_MODULES);
  localparam int unsigned PORT_W          = $clog2(BITS_PER_MODULE);
  localparam int unsigned NUM_W           = 6;
  localparam int unsigned PHASE_W         = 10;
  localparam int unsigned SAMPLE_W        = 9;
  localparam int unsigned INDEX_W         = 8;

  localparam logic [PHASE_W-1:0] PH_LOAD_HI   = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] PH_CLOCK_HI  = PHASE_W'(4);
  localparam logic [PHASE_W-1:0] PH_SAMPLE_0  = PHASE_W'(5);
  localparam logic [PHASE_W-1:0] PH_RESET_HI  = PHASE_W'(9);
  localparam logic [PHASE_W-1:0] PH_RESET_LO  = PHASE_W'(10);
  localparam logic [PHASE_W-1:0] PH_LOAD_LO   = PHASE_W'(11);
  localparam logic [PHASE_W-1:0] PH_SHIFT     = PHASE_W'(12);
  localparam logic [PHASE_W-1:0] PH_END_BASE  = PHASE_W'(10);
  localparam int unsigned        PH_PER_MOD_W = $clog2(2 * BITS_PER_MODULE);

  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(1);
  localparam logic [NUM_W-1:0] NUM_MAX   = NUM_W'(MAX_MODULES);

  typedef enum logic [1:0] {
    RPT_IDLE    = 2'd0,
    RPT_CHANGED = 2'd1,
    RPT_READY   = 2'd2
  } s88_fb_rpt_e;

  typedef struct packed {
    logic load_level;
    logic clock_level;
    logic reset_level;
    logic read_bit;
    logic report_ready;
  } s88_fb_result_t;

endpackage

// ===== hdl/s88_feedback_bus_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s88_feedback_bus_master: master for a shift-register feedback bus
// Sequences the load, clock and reset lines, samples the data line into a
// sensor store and reports scans that saw a change.
// ----------------------------------------------------------------------------
// Each input beat is either a bus tick or a read of one stored sensor bit, and
// produces exactly one result beat. A beat can be accepted on every clock
// cycle while the buffer has room: the work for one beat is a phase compare
// and a single bit update of the sensor store, and the result is registered
// in a two-entry result buffer (output register plus skid stage) that lets
// the input keep taking beats while a result waits; input ready falls only
// when both entries are full. The module count register is written through
// cfg_we_i and takes effect immediately; a count of zero behaves as one and
// a count above the store depth as the depth. The sensor store is cleared
// by reset, so no clearing pass is needed.
module s88_feedback_bus_master
  import s88_fb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [NUM_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic               data_in_i,
  input  logic [INDEX_W-1:0] bit_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               load_level_o,
  output logic               clock_level_o,
  output logic               reset_level_o,
  output logic               read_bit_o,
  output logic               report_ready_o
);

  logic           push;
  s88_fb_result_t result;
  s88_fb_result_t out_beat;

  // The bus state advances only on a beat that the buffer can take.
  assign push = in_valid_i && in_ready_o;

  s88_fb_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .action_i    (action_i),
    .data_in_i   (data_in_i),
    .bit_index_i (bit_index_i),
    .result_o    (result)
  );

  s88_fb_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_beat)
  );

  assign load_level_o   = out_beat.load_level;
  assign clock_level_o  = out_beat.clock_level;
  assign reset_level_o  = out_beat.reset_level;
  assign read_bit_o     = out_beat.read_bit;
  assign report_ready_o = out_beat.report_ready;

  // A full skid stage can only exist behind a held output beat.
  a_skid_behind_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("skid stage full while output register empty");

  // A stalled output beat is never dropped.
  a_stall_keeps_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("stalled result beat lost");

  // Once the head beat drains, the skid beat moves up and input reopens.
  a_drain_reopens : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o && out_valid_o)
    else $error("buffer failed to drain skid beat");

endmodule

// ===== hdl/s88_fb_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s88_fb_engine: bus sequencer and sensor store
// Holds the phase counter, line levels, report state and the sensor bits, and
// works out one result beat combinationally for each accepted item.
// ----------------------------------------------------------------------------
module s88_fb_engine
  import s88_fb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NUM_W-1:0]     cfg_wdata_i,
  input  logic                 push_i,
  input  logic                 action_i,
  input  logic                 data_in_i,
  input  logic [INDEX_W-1:0]   bit_index_i,
  output s88_fb_result_t       result_o
);

  logic [NUM_W-1:0]    num_modules_q;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  s88_fb_rpt_e         report_q, report_d;
  logic                load_q, load_d, clock_q, clock_d, reset_q, reset_d;
  logic [BITS_PER_MODULE-1:0] sensor_q [MAX_MODULES];

  logic [NUM_W-1:0]           eff_mod;
  logic [PHASE_W:0]           phase_end;
  logic [PHASE_W:0]           phase_inc;
  logic [MOD_IDX_W-1:0]       rd_addr;
  logic [NUM_W-1:0]           rd_mod;
  logic [PORT_W-1:0]          rd_port;
  logic [BITS_PER_MODULE-1:0] rd_word;
  logic                       in_range;
  logic                       do_sample;
  logic                       in_shift;
  logic                       wr_en;
  logic [BITS_PER_MODULE-1:0] wr_word;
  logic                       read_bit;

  // Out-of-range module counts are clamped into one to the store depth.
  always_comb begin
    eff_mod = num_modules_q;
    if (eff_mod == '0) begin
      eff_mod = NUM_W'(1);
    end else if (eff_mod > NUM_MAX) begin
      eff_mod = NUM_MAX;
    end
  end

  assign phase_end = {1'b0, PH_END_BASE}
                   + ((PHASE_W+1)'(eff_mod) << PH_PER_MOD_W);

  // One store port serves both the read beat and the sample of a tick.
  always_comb begin
    if (action_i) begin
      rd_mod  = NUM_W'(bit_index_i[INDEX_W-1:PORT_W]);
      rd_port = bit_index_i[PORT_W-1:0];
    end else begin
      rd_mod  = NUM_W'(sample_q[SAMPLE_W-1:PORT_W]);
      rd_port = sample_q[PORT_W-1:0];
    end
    rd_addr  = rd_mod[MOD_IDX_W-1:0];
    in_range = rd_mod < eff_mod;
    rd_word  = sensor_q[rd_addr];
  end

  always_comb begin
    phase_d   = phase_q;
    sample_d  = sample_q;
    report_d  = report_q;
    load_d    = load_q;
    clock_d   = clock_q;
    reset_d   = reset_q;
    wr_en     = 1'b0;
    wr_word   = rd_word;
    read_bit  = 1'b0;
    in_shift  = ({1'b0, phase_q} >= {1'b0, PH_SHIFT}) && ({1'b0, phase_q} < phase_end);
    do_sample = (phase_q == PH_SAMPLE_0) || (in_shift && phase_q[0]);
    phase_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);

    if (action_i) begin
      read_bit = in_range & rd_word[rd_port];
    end else begin
      if (phase_q == PH_LOAD_HI)  load_d  = 1'b1;
      if (phase_q == PH_CLOCK_HI) clock_d = 1'b1;
      if (phase_q == PH_RESET_HI) reset_d = 1'b1;
      if (phase_q == PH_RESET_LO) reset_d = 1'b0;
      if (phase_q == PH_LOAD_LO)  load_d  = 1'b0;
      if (in_shift && !phase_q[0]) clock_d = 1'b1;

      if (do_sample) begin
        clock_d  = 1'b0;
        sample_d = sample_q + SAMPLE_W'(1);
        if (in_range && (rd_word[rd_port] != data_in_i)) begin
          wr_en            = 1'b1;
          wr_word[rd_port] = data_in_i;
          report_d         = RPT_CHANGED;
        end
      end

      // End of scan: all lines drop and a pending change becomes a report.
      if (phase_inc >= phase_end) begin
        phase_d  = '0;
        sample_d = '0;
        load_d   = 1'b0;
        clock_d  = 1'b0;
        reset_d  = 1'b0;
        if (report_d == RPT_CHANGED) report_d = RPT_READY;
      end else begin
        phase_d = phase_inc[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_modules_q <= NUM_RESET;
      phase_q       <= '0;
      sample_q      <= '0;
      report_q      <= RPT_IDLE;
      load_q        <= 1'b0;
      clock_q       <= 1'b0;
      reset_q       <= 1'b0;
    end else begin
      if (cfg_we_i) num_modules_q <= cfg_wdata_i;
      if (push_i) begin
        phase_q  <= phase_d;
        sample_q <= sample_d;
        report_q <= report_d;
        load_q   <= load_d;
        clock_q  <= clock_d;
        reset_q  <= reset_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_MODULES; i++) sensor_q[i] <= '0;
    end else if (push_i && wr_en) begin
      sensor_q[rd_addr] <= wr_word;
    end
  end

  always_comb begin
    result_o.load_level   = load_d;
    result_o.clock_level  = clock_d;
    result_o.reset_level  = reset_d;
    result_o.read_bit     = read_bit;
    result_o.report_ready = (report_d == RPT_READY);
  end

endmodule

// ===== hdl/s88_fb_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s88_fb_skid: result register with a skid stage
// Holds result beats so that input ready depends only on registered state.
// ----------------------------------------------------------------------------
module s88_fb_skid
  import s88_fb_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  s88_fb_result_t data_i,
  output logic           ready_o,
  output logic           valid_o,
  input  logic           ready_i,
  output s88_fb_result_t data_o
);

  s88_fb_result_t out_q, skid_q;
  logic           out_valid_q, skid_valid_q;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !ready_i) begin
      if (push_i) skid_valid_q <= 1'b1;
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !ready_i) begin
      if (push_i) skid_q <= data_i;
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i) begin
      out_q <= data_i;
    end
  end

endmodule
